// File: rtl/vgm_command_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command stream decoder
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VGM_COMMAND_STREAM_DECODER_DEFINES_SVH
`define VGM_COMMAND_STREAM_DECODER_DEFINES_SVH

// same-cycle implication
`define VGM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgm decoder: assertion failed");

// next-cycle implication
`define VGM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vgm decoder: assertion failed");

`endif

// File: rtl/vgm_pkg.sv
// ----------------------------------------------------------------------------
// vgm_pkg
// Result kinds, queue entry and divider request/response types.
// ----------------------------------------------------------------------------
package vgm_pkg;

  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_WAIT     = 3'd1;
  localparam logic [2:0] KIND_START    = 3'd2;
  localparam logic [2:0] KIND_STOP     = 3'd3;
  localparam logic [2:0] KIND_FINISHED = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_WAIT,
    CMD_START,
    CMD_STOP,
    CMD_END,
    CMD_ERROR
  } cmd_t;

  // START carries the tone period in value[11:0]
  typedef struct packed {
    cmd_t        op;
    logic [15:0] value;
  } cmd_entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/vgm_command_stream_decoder.sv
// ----------------------------------------------------------------------------
// vgm_command_stream_decoder
// Sound-log command stream decoder, top level.
// ----------------------------------------------------------------------------
// One stream byte is taken per cycle whenever the command queue has room.
// Chip writes, waits and speaker stops leave at one beat a cycle unless the
// output stalls; an end of stream gives six beats and a parse error five. A
// speaker start runs one or two 32-step divisions in the divider (the second
// only if the first quotient is nonzero) from queue pop to the start beat,
// while the queue fills and then holds off further bytes. After the finished
// or error beat all further bytes are accepted and dropped. ay_clock_hz must
// be written through cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
`include "vgm_command_stream_decoder_defines.svh"

module vgm_command_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [15:0] out_value,
  output logic        out_last
);

  logic [31:0]         ay_clock_r;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  vgm_pkg::cmd_entry_t q_entry;
  vgm_pkg::cmd_entry_t q_head;
  vgm_pkg::div_req_t   div_req;
  vgm_pkg::div_rsp_t   div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ay_clock_r <= '0;
    end else if (cfg_wr_en) begin
      ay_clock_r <= cfg_wr_data;
    end
  end

  assign in_stall = q_full;

  vgm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stream_end(in_stream_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  vgm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  vgm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  vgm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ay_clock_hz(ay_clock_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_value  (out_value),
    .out_last   (out_last)
  );

  `VGM_ASSERT_IMP(a_kind_range, out_valid, out_kind <= vgm_pkg::KIND_ERROR)
  `VGM_ASSERT_IMP(a_start_even, out_valid && out_kind == vgm_pkg::KIND_START, !out_value[0])
  `VGM_ASSERT_IMP(a_fin_last, out_valid && out_kind == vgm_pkg::KIND_FINISHED, out_last)
  `VGM_ASSERT_NXT(a_quiet_after_fin,
                  out_valid && !out_stall && out_kind == vgm_pkg::KIND_FINISHED, !out_valid)

endmodule

// File: rtl/vgm_front.sv
// ----------------------------------------------------------------------------
// vgm_front
// Byte parser: tracks the command phase and posts one queue entry per beat
// at most.
// ----------------------------------------------------------------------------
module vgm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_stream_end,
  input  logic                   q_full,
  output logic                   q_push,
  output vgm_pkg::cmd_entry_t    q_entry
);

  typedef enum logic [3:0] {
    PH_OPCODE,
    PH_SKIP,
    PH_CHIPDATA,
    PH_WAITARG,
    PH_MARKER,
    PH_BLKTYPE,
    PH_BLKSIZE,
    PH_AYREG,
    PH_AYDATA
  } phase_t;

  localparam logic [7:0]  OP_CHIP    = 8'h50;
  localparam logic [7:0]  OP_WAIT16  = 8'h61;
  localparam logic [7:0]  OP_WAITNT  = 8'h62;
  localparam logic [7:0]  OP_WAITPAL = 8'h63;
  localparam logic [7:0]  OP_END     = 8'h66;
  localparam logic [7:0]  OP_DBLOCK  = 8'h67;
  localparam logic [7:0]  OP_PCMRAM  = 8'h68;
  localparam logic [7:0]  OP_AY      = 8'ha0;
  localparam logic [7:0]  MARKER     = 8'h66;
  localparam logic [15:0] WAIT_NT    = 16'd735;
  localparam logic [15:0] WAIT_PAL   = 16'd882;
  localparam logic [31:0] PCM_SKIP   = 32'd13;
  localparam logic [7:0]  AY_TONE_LO = 8'd0;
  localparam logic [7:0]  AY_TONE_HI = 8'd1;
  localparam logic [7:0]  AY_MIXER   = 8'd7;
  localparam logic [7:0]  AY_VOL_A   = 8'd8;

  function automatic logic [3:0] skip_length(input logic [7:0] op);
    logic [3:0] len;
    len = 4'd0;
    if ((op >= 8'h30 && op <= 8'h3f) || op == 8'h4f || op == 8'h94) len = 4'd1;
    else if ((op >= 8'h40 && op <= 8'h4e) || (op >= 8'h51 && op <= 8'h5f) ||
             (op >= 8'ha1 && op <= 8'hbf)) len = 4'd2;
    else if ((op >= 8'hc0 && op <= 8'hdf) || op == 8'he1) len = 4'd3;
    else if (op == 8'he0 || op >= 8'he2 || op == 8'h90 || op == 8'h91 ||
             op == 8'h95) len = 4'd4;
    else if (op == 8'h92) len = 4'd5;
    else if (op == 8'h93) len = 4'd10;
    return len;
  endfunction

  phase_t      phase_r,    phase_nxt;
  logic [7:0]  opcode_r,   opcode_nxt;
  logic [31:0] skip_r,     skip_nxt;
  logic [23:0] arg_r,      arg_nxt;
  logic [1:0]  idx_r,      idx_nxt;
  logic [11:0] period_r,   period_nxt;
  logic        finished_r, finished_nxt;

  logic        accept;
  logic [3:0]  len;
  logic [31:0] blk_size;
  logic [11:0] new_period;

  assign accept   = in_valid && !q_full;
  assign len      = skip_length(in_data_byte);
  assign blk_size = {in_data_byte, arg_r};

  always_comb begin
    phase_nxt     = phase_r;
    opcode_nxt    = opcode_r;
    skip_nxt      = skip_r;
    arg_nxt       = arg_r;
    idx_nxt       = idx_r;
    period_nxt    = period_r;
    finished_nxt  = finished_r;
    q_push        = 1'b0;
    q_entry.op    = vgm_pkg::CMD_WRITE;
    q_entry.value = {8'd0, in_data_byte};
    new_period    = {in_data_byte[3:0], period_r[7:0]};

    if (accept && !finished_r) begin
      if (in_stream_end) begin
        q_push       = 1'b1;
        q_entry.op   = vgm_pkg::CMD_END;
        finished_nxt = 1'b1;
        phase_nxt    = PH_OPCODE;
        skip_nxt     = '0;
        arg_nxt      = '0;
        idx_nxt      = '0;
      end else begin
        case (phase_r)
          PH_SKIP: begin
            if (skip_r <= 32'd1) begin
              phase_nxt = PH_OPCODE;
              skip_nxt  = '0;
            end else begin
              skip_nxt = skip_r - 32'd1;
            end
          end
          PH_CHIPDATA: begin
            q_push    = 1'b1;
            phase_nxt = PH_OPCODE;
          end
          PH_WAITARG: begin
            if (idx_r == 2'd0) begin
              arg_nxt = {16'd0, in_data_byte};
              idx_nxt = 2'd1;
            end else begin
              q_push        = 1'b1;
              q_entry.op    = vgm_pkg::CMD_WAIT;
              q_entry.value = {in_data_byte, arg_r[7:0]};
              phase_nxt     = PH_OPCODE;
              arg_nxt       = '0;
              idx_nxt       = '0;
            end
          end
          PH_MARKER: begin
            if (in_data_byte != MARKER) begin
              q_push       = 1'b1;
              q_entry.op   = vgm_pkg::CMD_ERROR;
              finished_nxt = 1'b1;
              phase_nxt    = PH_OPCODE;
            end else if (opcode_r == OP_DBLOCK) begin
              phase_nxt = PH_BLKTYPE;
            end else begin
              skip_nxt  = PCM_SKIP;
              phase_nxt = PH_SKIP;
            end
          end
          PH_BLKTYPE: begin
            arg_nxt   = '0;
            idx_nxt   = '0;
            phase_nxt = PH_BLKSIZE;
          end
          PH_BLKSIZE: begin
            case (idx_r)
              2'd0:    arg_nxt = {arg_r[23:8], in_data_byte};
              2'd1:    arg_nxt = {arg_r[23:16], in_data_byte, arg_r[7:0]};
              2'd2:    arg_nxt = {in_data_byte, arg_r[15:0]};
              default: arg_nxt = '0;
            endcase
            if (idx_r == 2'd3) begin
              idx_nxt = '0;
              if (blk_size != 32'd0) begin
                skip_nxt  = blk_size;
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = PH_OPCODE;
              end
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          PH_AYREG: begin
            arg_nxt   = {16'd0, in_data_byte};
            phase_nxt = PH_AYDATA;
          end
          PH_AYDATA: begin
            phase_nxt  = PH_OPCODE;
            arg_nxt    = '0;
            q_entry.op = vgm_pkg::CMD_START;
            if (arg_r[7:0] == AY_TONE_LO) begin
              period_nxt = {period_r[11:8], in_data_byte};
            end else if (arg_r[7:0] == AY_TONE_HI) begin
              period_nxt    = new_period;
              q_entry.value = {4'd0, new_period};
              q_push        = (new_period != 12'd0);
            end else if (arg_r[7:0] == AY_MIXER) begin
              q_entry.value = {4'd0, period_r};
              q_push        = in_data_byte[0] && (period_r != 12'd0);
            end else if (arg_r[7:0] == AY_VOL_A) begin
              q_entry.op = vgm_pkg::CMD_STOP;
              q_push     = !in_data_byte[0];
            end
          end
          default: begin
            opcode_nxt = in_data_byte;
            arg_nxt    = '0;
            idx_nxt    = '0;
            if (len != 4'd0) begin
              skip_nxt  = {28'd0, len};
              phase_nxt = PH_SKIP;
            end else if (in_data_byte == OP_CHIP) begin
              phase_nxt = PH_CHIPDATA;
            end else if (in_data_byte == OP_WAIT16) begin
              phase_nxt = PH_WAITARG;
            end else if (in_data_byte == OP_WAITNT) begin
              q_push        = 1'b1;
              q_entry.op    = vgm_pkg::CMD_WAIT;
              q_entry.value = WAIT_NT;
            end else if (in_data_byte == OP_WAITPAL) begin
              q_push        = 1'b1;
              q_entry.op    = vgm_pkg::CMD_WAIT;
              q_entry.value = WAIT_PAL;
            end else if (in_data_byte == OP_END) begin
              q_push       = 1'b1;
              q_entry.op   = vgm_pkg::CMD_END;
              finished_nxt = 1'b1;
              phase_nxt    = PH_OPCODE;
              skip_nxt     = '0;
            end else if (in_data_byte == OP_DBLOCK || in_data_byte == OP_PCMRAM) begin
              phase_nxt = PH_MARKER;
            end else if (in_data_byte[7:4] == 4'h7) begin
              q_push        = 1'b1;
              q_entry.op    = vgm_pkg::CMD_WAIT;
              q_entry.value = {12'd0, in_data_byte[3:0]} + 16'd1;
              phase_nxt     = PH_OPCODE;
            end else if (in_data_byte[7:4] == 4'h8) begin
              phase_nxt = PH_OPCODE;
            end else if (in_data_byte == OP_AY) begin
              phase_nxt = PH_AYREG;
            end else begin
              q_push       = 1'b1;
              q_entry.op   = vgm_pkg::CMD_ERROR;
              finished_nxt = 1'b1;
              phase_nxt    = PH_OPCODE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPCODE;
      opcode_r   <= '0;
      skip_r     <= '0;
      arg_r      <= '0;
      idx_r      <= '0;
      period_r   <= '0;
      finished_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      skip_r     <= skip_nxt;
      arg_r      <= arg_nxt;
      idx_r      <= idx_nxt;
      period_r   <= period_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

// File: rtl/vgm_queue.sv
// ----------------------------------------------------------------------------
// vgm_queue
// Small FIFO of parsed commands between parser and sequencer.
// ----------------------------------------------------------------------------
module vgm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vgm_pkg::cmd_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output vgm_pkg::cmd_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vgm_pkg::cmd_entry_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/vgm_div.sv
// ----------------------------------------------------------------------------
// vgm_div
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vgm_pkg::div_req_t req,
  output vgm_pkg::div_rsp_t rsp
);

  localparam int W     = 32;
  localparam int CNT_W = $clog2(W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dsr_r;

  logic [W:0]       sh;
  logic             ge;
  logic [W-1:0]     rem_nxt;
  logic [W-1:0]     quo_nxt;

  assign sh      = {rem_r, quo_r[W-1]};
  assign ge      = (sh >= {1'b0, dsr_r});
  assign rem_nxt = ge ? W'(sh - {1'b0, dsr_r}) : sh[W-1:0];
  assign quo_nxt = {quo_r[W-2:0], ge};

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

// File: rtl/vgm_back.sv
// ----------------------------------------------------------------------------
// vgm_back
// Sequencer: expands queued commands into result beats, runs the divider
// for speaker starts and holds the output register.
// ----------------------------------------------------------------------------
module vgm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         ay_clock_hz,
  input  logic                q_valid,
  input  vgm_pkg::cmd_entry_t q_head,
  output logic                q_pop,
  output vgm_pkg::div_req_t   div_req,
  input  vgm_pkg::div_rsp_t   div_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_kind,
  output logic [15:0]         out_value,
  output logic                out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUTE,
    S_TAIL,
    S_FIN,
    S_DIV1,
    S_DIV2,
    S_RES
  } state_t;

  localparam logic [31:0]      SPK_CLK = 32'h1234dc;
  localparam logic [15:0]      DIV_MAX = 16'hfffe;
  localparam logic [3:0][7:0]  MUTE    = {8'hff, 8'hdf, 8'hbf, 8'h9f};

  state_t              state_r,  state_nxt;
  vgm_pkg::cmd_entry_t cmd_r,    cmd_nxt;
  logic [1:0]          cnt_r,    cnt_nxt;
  logic [15:0]         res_r,    res_nxt;
  logic                valid_r,  valid_nxt;
  logic [2:0]          kind_r,   kind_nxt;
  logic [15:0]         value_r,  value_nxt;
  logic                last_r,   last_nxt;
  logic                load_ok;

  assign load_ok   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    cnt_nxt          = cnt_r;
    res_nxt          = res_r;
    valid_nxt        = valid_r && out_stall;
    kind_nxt         = kind_r;
    value_nxt        = value_r;
    last_nxt         = last_r;
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = ay_clock_hz;
    div_req.divisor  = {16'd0, q_head.value[11:0], 4'd0};

    case (state_r)
      S_IDLE: begin
        if (q_valid && load_ok) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          case (q_head.op)
            vgm_pkg::CMD_WRITE: begin
              valid_nxt = 1'b1;
              kind_nxt  = vgm_pkg::KIND_WRITE;
              value_nxt = q_head.value;
              last_nxt  = 1'b1;
            end
            vgm_pkg::CMD_WAIT: begin
              valid_nxt = 1'b1;
              kind_nxt  = vgm_pkg::KIND_WAIT;
              value_nxt = q_head.value;
              last_nxt  = 1'b1;
            end
            vgm_pkg::CMD_STOP: begin
              valid_nxt = 1'b1;
              kind_nxt  = vgm_pkg::KIND_STOP;
              value_nxt = '0;
              last_nxt  = 1'b1;
            end
            vgm_pkg::CMD_START: begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV1;
            end
            default: begin
              valid_nxt = 1'b1;
              kind_nxt  = vgm_pkg::KIND_WRITE;
              value_nxt = {8'd0, MUTE[0]};
              last_nxt  = 1'b0;
              cnt_nxt   = 2'd1;
              state_nxt = S_MUTE;
            end
          endcase
        end
      end
      S_MUTE: begin
        if (load_ok) begin
          valid_nxt = 1'b1;
          kind_nxt  = vgm_pkg::KIND_WRITE;
          value_nxt = {8'd0, MUTE[cnt_r]};
          last_nxt  = 1'b0;
          cnt_nxt   = cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (load_ok) begin
          valid_nxt = 1'b1;
          if (cmd_r.op == vgm_pkg::CMD_END) begin
            kind_nxt  = vgm_pkg::KIND_STOP;
            value_nxt = '0;
            last_nxt  = 1'b0;
            state_nxt = S_FIN;
          end else begin
            kind_nxt  = vgm_pkg::KIND_ERROR;
            value_nxt = cmd_r.value;
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (load_ok) begin
          valid_nxt = 1'b1;
          kind_nxt  = vgm_pkg::KIND_FINISHED;
          value_nxt = '0;
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV1: begin
        div_req.dividend = SPK_CLK;
        div_req.divisor  = div_rsp.quotient;
        if (div_rsp.done) begin
          if (div_rsp.quotient == 32'd0) begin
            res_nxt   = DIV_MAX;
            state_nxt = S_RES;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > {16'd0, DIV_MAX}) begin
            res_nxt = DIV_MAX;
          end else begin
            res_nxt = div_rsp.quotient[15:0] & DIV_MAX;
          end
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (load_ok) begin
          valid_nxt = 1'b1;
          kind_nxt  = vgm_pkg::KIND_START;
          value_nxt = res_r;
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    cmd_r   <= cmd_nxt;
    res_r   <= res_nxt;
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

endmodule

// File: dv/vgm_stream_codes_pkg.sv
// ----------------------------------------------------------------------------
// Stream command codes
// Opcodes, markers and tone chip registers used by the decoder testbench,
// plus the argument length table for commands that are skipped.
// ----------------------------------------------------------------------------
package vgm_stream_codes_pkg;

  localparam logic [7:0] OP_CHIP_WRITE     = 8'h50;
  localparam logic [7:0] OP_WAIT_N         = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC      = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL       = 8'h63;
  localparam logic [7:0] OP_END            = 8'h66;
  localparam logic [7:0] OP_DATA_BLOCK     = 8'h67;
  localparam logic [7:0] OP_PCM_WRITE      = 8'h68;
  localparam logic [7:0] OP_WAIT_SHORT     = 8'h70;
  localparam logic [7:0] OP_WAIT_SHORT_END = 8'h7f;
  localparam logic [7:0] OP_DAC_WAIT       = 8'h80;
  localparam logic [7:0] OP_DAC_WAIT_END   = 8'h8f;
  localparam logic [7:0] OP_AY_WRITE       = 8'ha0;

  localparam logic [7:0] BLOCK_MARKER      = 8'h66;
  localparam int         PCM_PAYLOAD_LEN   = 13;

  localparam logic [7:0] AY_TONE_FINE      = 8'd0;
  localparam logic [7:0] AY_TONE_COARSE    = 8'd1;
  localparam logic [7:0] AY_MIXER          = 8'd7;
  localparam logic [7:0] AY_AMP_A          = 8'd8;

  // argument bytes of commands for chips that are not emulated; 0 = none
  function automatic int cmd_arg_len(logic [7:0] op);
    if ((op >= 8'h30 && op <= 8'h3f) || op == 8'h4f || op == 8'h94) return 1;
    if ((op >= 8'h40 && op <= 8'h4e) || (op >= 8'h51 && op <= 8'h5f) ||
        (op >= 8'ha1 && op <= 8'hbf)) return 2;
    if ((op >= 8'hc0 && op <= 8'hdf) || op == 8'he1) return 3;
    if (op == 8'he0 || op >= 8'he2 || op == 8'h90 || op == 8'h91 || op == 8'h95)
      return 4;
    if (op == 8'h92) return 5;
    if (op == 8'h93) return 10;
    return 0;
  endfunction

endpackage

// File: dv/vgm_stream_checker.sv
// ----------------------------------------------------------------------------
// Command stream decoder checker
// Watches the stream, configuration and result channels, decodes every
// accepted stream beat into the actions it should cause and compares each
// accepted result beat with the oldest outstanding action.
// ----------------------------------------------------------------------------
module vgm_stream_checker
  import vgm_pkg::*;
  import vgm_stream_codes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [15:0] out_value,
  input  logic        out_last,
  output int          failures,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] PIT_CLOCK  = 32'h0012_34dc;
  localparam logic [31:0] DIV_CEIL   = 32'h0000_fffe;
  localparam logic [31:0] MUTE_SEQ   = 32'h9fbf_dfff;
  localparam logic [15:0] WAIT_60HZ  = 16'd735;
  localparam logic [15:0] WAIT_50HZ  = 16'd882;

  typedef enum logic [3:0] {
    ST_OPCODE,
    ST_SKIP,
    ST_CHIP_DATA,
    ST_WAIT_ARG,
    ST_MARKER,
    ST_BLK_TYPE,
    ST_BLK_SIZE,
    ST_AY_REG,
    ST_AY_DATA
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic        last;
  } action_t;

  parse_state_t state;
  logic [7:0]   opcode;
  logic [31:0]  skip_left;
  logic [31:0]  arg_word;
  logic [1:0]   arg_idx;
  logic [11:0]  tone_period;
  logic         stream_done;
  logic [31:0]  ay_clock;

  action_t step_actions[$];
  action_t pending_actions[$];
  int      fail_count    = 0;
  int      checked_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("check: beat %0d %s: got %0h expected %0h", checked_count, what, got, want);
    fail_count++;
  endtask

  task automatic add_action(input logic [2:0] kind, input logic [15:0] value);
    action_t a;
    a.kind  = kind;
    a.value = value;
    a.last  = 1'b0;
    step_actions.push_back(a);
  endtask

  task automatic go_idle();
    state     = ST_OPCODE;
    skip_left = '0;
    arg_word  = '0;
    arg_idx   = '0;
  endtask

  task automatic mute_all();
    for (int i = 0; i < 4; i++) add_action(KIND_WRITE, {8'd0, MUTE_SEQ[31-8*i -: 8]});
  endtask

  task automatic close_stream();
    mute_all();
    add_action(KIND_STOP, 16'd0);
    add_action(KIND_FINISHED, 16'd0);
    stream_done = 1'b1;
    go_idle();
  endtask

  task automatic abort_stream(input logic [7:0] b);
    mute_all();
    add_action(KIND_ERROR, {8'd0, b});
    stream_done = 1'b1;
    go_idle();
  endtask

  task automatic start_speaker();
    logic [31:0] freq;
    logic [31:0] div;
    if (tone_period != 12'd0) begin
      freq = ay_clock / (32'd16 * {20'd0, tone_period});
      if (freq == 32'd0) begin
        div = DIV_CEIL;
      end else begin
        div = PIT_CLOCK / freq;
        if (div > DIV_CEIL) div = DIV_CEIL;
        div[0] = 1'b0;
      end
      add_action(KIND_START, div[15:0]);
    end
  endtask

  task automatic begin_command(input logic [7:0] b);
    int len;
    len      = cmd_arg_len(b);
    opcode   = b;
    arg_word = '0;
    arg_idx  = '0;
    if (len != 0) begin
      skip_left = len;
      state     = ST_SKIP;
    end else if (b == OP_CHIP_WRITE) begin
      state = ST_CHIP_DATA;
    end else if (b == OP_WAIT_N) begin
      state = ST_WAIT_ARG;
    end else if (b == OP_WAIT_NTSC) begin
      add_action(KIND_WAIT, WAIT_60HZ);
    end else if (b == OP_WAIT_PAL) begin
      add_action(KIND_WAIT, WAIT_50HZ);
    end else if (b == OP_END) begin
      close_stream();
    end else if (b == OP_DATA_BLOCK || b == OP_PCM_WRITE) begin
      state = ST_MARKER;
    end else if (b >= OP_WAIT_SHORT && b <= OP_WAIT_SHORT_END) begin
      add_action(KIND_WAIT, {12'd0, b[3:0]} + 16'd1);
    end else if (b >= OP_DAC_WAIT && b <= OP_DAC_WAIT_END) begin
      // consumed silently
    end else if (b == OP_AY_WRITE) begin
      state = ST_AY_REG;
    end else begin
      abort_stream(b);
    end
  endtask

  task automatic decode_stream_byte(input logic [7:0] b, input logic fin);
    action_t     a;
    logic [31:0] size;
    logic [7:0]  ay_reg;
    step_actions.delete();
    if (!stream_done) begin
      if (fin) begin
        close_stream();
      end else begin
        case (state)
          ST_SKIP: begin
            if (skip_left <= 32'd1) go_idle();
            else skip_left = skip_left - 32'd1;
          end
          ST_CHIP_DATA: begin
            add_action(KIND_WRITE, {8'd0, b});
            go_idle();
          end
          ST_WAIT_ARG: begin
            if (arg_idx == 2'd0) begin
              arg_word = {24'd0, b};
              arg_idx  = 2'd1;
            end else begin
              add_action(KIND_WAIT, {b, arg_word[7:0]});
              go_idle();
            end
          end
          ST_MARKER: begin
            if (b != BLOCK_MARKER) begin
              abort_stream(b);
            end else if (opcode == OP_DATA_BLOCK) begin
              state = ST_BLK_TYPE;
            end else begin
              skip_left = PCM_PAYLOAD_LEN;
              state     = ST_SKIP;
            end
          end
          ST_BLK_TYPE: begin
            arg_word = '0;
            arg_idx  = '0;
            state    = ST_BLK_SIZE;
          end
          ST_BLK_SIZE: begin
            arg_word = arg_word | ({24'd0, b} << (8 * arg_idx));
            if (arg_idx == 2'd3) begin
              size = arg_word;
              go_idle();
              if (size != 32'd0) begin
                skip_left = size;
                state     = ST_SKIP;
              end
            end else begin
              arg_idx = arg_idx + 2'd1;
            end
          end
          ST_AY_REG: begin
            arg_word = {24'd0, b};
            state    = ST_AY_DATA;
          end
          ST_AY_DATA: begin
            ay_reg = arg_word[7:0];
            go_idle();
            if (ay_reg == AY_TONE_FINE) begin
              tone_period[7:0] = b;
            end else if (ay_reg == AY_TONE_COARSE) begin
              tone_period[11:8] = b[3:0];
              start_speaker();
            end else if (ay_reg == AY_MIXER) begin
              if (b[0]) start_speaker();
            end else if (ay_reg == AY_AMP_A) begin
              if (!b[0]) add_action(KIND_STOP, 16'd0);
            end
          end
          default: begin_command(b);
        endcase
      end
    end
    for (int i = 0; i < step_actions.size(); i++) begin
      a      = step_actions[i];
      a.last = (i == step_actions.size() - 1);
      pending_actions.push_back(a);
    end
  endtask

  task automatic compare_result();
    action_t want;
    if (pending_actions.size() == 0) begin
      report_mismatch("result with nothing outstanding, kind", out_kind, 0);
    end else begin
      want = pending_actions.pop_front();
      if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
      if (out_value !== want.value) report_mismatch("value", out_value, want.value);
      if (out_last !== want.last) report_mismatch("last", out_last, want.last);
    end
    checked_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      go_idle();
      opcode      = '0;
      tone_period = '0;
      stream_done = 1'b0;
      ay_clock    = '0;
      pending_actions.delete();
    end else begin
      if (cfg_wr_en) ay_clock = cfg_wr_data;
      if (in_valid && !in_stall) decode_stream_byte(in_data_byte, in_stream_end);
      if (out_valid && !out_stall) compare_result();
    end
    failures <= fail_count;
    pending  <= pending_actions.size();
    checked  <= checked_count;
  end

endmodule

// File: dv/vgm_command_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// Command stream decoder testbench
// Feeds one command stream through the decoder: a directed opening, then
// random well-formed commands under several AY clock settings, with random
// gaps and stalls, one long result hold-off and one gap-free stretch. The
// stream is closed by a randomly chosen end or error case, and a few dropped
// beats follow. Results are checked by vgm_stream_checker.
// ----------------------------------------------------------------------------
module vgm_command_stream_decoder_test;
  import vgm_stream_codes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int RANDOM_BEATS    = 90;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int IDLE_PCT        = 26;
  localparam int DROPPED_BEATS   = 8;

  typedef enum {
    CLOSE_END_OPCODE,
    CLOSE_END_FLAG,
    CLOSE_FLAG_MID_COMMAND,
    CLOSE_BAD_MARKER,
    CLOSE_UNKNOWN_OPCODE
  } stream_close_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_stream_end;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [15:0] out_value;
  logic        out_last;

  int            failures;
  int            pending;
  int            checked;
  int            beats_sent;
  int            settings_used;
  logic          hold_req;
  logic          steady;
  stream_close_t close_mode;

  vgm_command_stream_decoder uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_stream_end(in_stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_last     (out_last)
  );

  vgm_stream_checker action_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_stream_end(in_stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_last     (out_last),
    .failures     (failures),
    .pending      (pending),
    .checked      (checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_stream_end <= fin;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_ay(input logic [7:0] ay_reg, input logic [7:0] data);
    send_beat(OP_AY_WRITE, 1'b0);
    send_beat(ay_reg, 1'b0);
    send_beat(data, 1'b0);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ay_clock(input logic [31:0] hz);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_command();
    int          pick;
    int          sel;
    logic [7:0]  op;
    logic [7:0]  ay_reg;
    logic [31:0] size;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_beat(OP_CHIP_WRITE, 1'b0);
      send_beat($urandom_range(255), 1'b0);
    end else if (pick < 23) begin
      send_beat(OP_WAIT_N, 1'b0);
      send_beat($urandom_range(255), 1'b0);
      send_beat($urandom_range(255), 1'b0);
    end else if (pick < 28) begin
      send_beat($urandom_range(1) ? OP_WAIT_NTSC : OP_WAIT_PAL, 1'b0);
    end else if (pick < 36) begin
      send_beat(OP_WAIT_SHORT | $urandom_range(15), 1'b0);
    end else if (pick < 40) begin
      send_beat(OP_DAC_WAIT | $urandom_range(15), 1'b0);
    end else if (pick < 68) begin
      sel = $urandom_range(9);
      if (sel < 3) ay_reg = AY_TONE_FINE;
      else if (sel < 6) ay_reg = AY_TONE_COARSE;
      else if (sel == 6) ay_reg = AY_MIXER;
      else if (sel == 7) ay_reg = AY_AMP_A;
      else ay_reg = $urandom_range(255);
      send_ay(ay_reg, $urandom_range(255));
    end else if (pick < 83) begin
      do op = $urandom_range(255); while (cmd_arg_len(op) == 0);
      send_beat(op, 1'b0);
      repeat (cmd_arg_len(op)) send_beat($urandom_range(255), 1'b0);
    end else if (pick < 93) begin
      size = ($urandom_range(19) == 0) ? 32'd256 + $urandom_range(40) : $urandom_range(12);
      send_beat(OP_DATA_BLOCK, 1'b0);
      send_beat(BLOCK_MARKER, 1'b0);
      send_beat($urandom_range(255), 1'b0);
      for (int i = 0; i < 4; i++) send_beat(size[8*i +: 8], 1'b0);
      repeat (size) send_beat($urandom_range(255), 1'b0);
    end else begin
      send_beat(OP_PCM_WRITE, 1'b0);
      send_beat(BLOCK_MARKER, 1'b0);
      repeat (PCM_PAYLOAD_LEN) send_beat($urandom_range(255), 1'b0);
    end
  endtask

  task automatic random_phase();
    int start;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) send_random_command();
  endtask

  task automatic close_stream_randomly();
    logic [7:0] b;
    close_mode = stream_close_t'($urandom_range(4));
    case (close_mode)
      CLOSE_END_OPCODE: send_beat(OP_END, 1'b0);
      CLOSE_END_FLAG: send_beat($urandom_range(255), 1'b1);
      CLOSE_FLAG_MID_COMMAND: begin
        send_beat(OP_WAIT_N, 1'b0);
        send_beat($urandom_range(255), 1'b0);
        send_beat($urandom_range(255), 1'b1);
      end
      CLOSE_BAD_MARKER: begin
        send_beat($urandom_range(1) ? OP_DATA_BLOCK : OP_PCM_WRITE, 1'b0);
        do b = $urandom_range(255); while (b == BLOCK_MARKER);
        send_beat(b, 1'b0);
      end
      default: begin
        do b = $urandom_range(255);
        while (cmd_arg_len(b) != 0 || b == OP_CHIP_WRITE || b == OP_AY_WRITE ||
               (b >= OP_WAIT_N && b <= OP_WAIT_PAL) ||
               (b >= OP_END && b <= OP_PCM_WRITE) ||
               (b >= OP_WAIT_SHORT && b <= OP_DAC_WAIT_END));
        send_beat(b, 1'b0);
      end
    endcase
    // everything after the close is taken and dropped
    for (int i = 0; i < DROPPED_BEATS; i++) send_beat($urandom_range(255), i[0]);
  endtask

  // result side: random stalls, one long hold-off, none while steady
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_OFF_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    beats_sent    = 0;
    settings_used = 0;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_data_byte  <= '0;
    in_stream_end <= 1'b0;
    hold_req      <= 1'b0;
    steady        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_ay_clock(32'hffff_ffff);
    send_beat(OP_CHIP_WRITE, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(OP_CHIP_WRITE, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(OP_WAIT_N, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(OP_WAIT_N, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(OP_WAIT_NTSC, 1'b0);
    send_beat(OP_WAIT_PAL, 1'b0);
    send_beat(OP_WAIT_SHORT, 1'b0);
    send_beat(OP_WAIT_SHORT_END, 1'b0);
    send_beat(OP_DAC_WAIT, 1'b0);
    send_beat(OP_DAC_WAIT_END, 1'b0);
    send_ay(AY_MIXER, 8'h01);        // tone period still zero: no start
    send_ay(AY_TONE_FINE, 8'h01);
    send_ay(AY_TONE_COARSE, 8'h00);  // fastest tone, divisor rounds to zero
    random_phase();

    write_ay_clock(32'd0);
    random_phase();

    write_ay_clock(32'd1_000_000);
    send_ay(AY_TONE_FINE, 8'hff);
    send_ay(AY_TONE_COARSE, 8'h0f);  // slowest tone, divisor saturates
    hold_req <= 1'b1;
    random_phase();

    write_ay_clock(32'd1_773_400);
    steady <= 1'b1;
    random_phase();
    steady <= 1'b0;

    write_ay_clock($urandom);
    random_phase();
    close_stream_randomly();

    drain_block();
    $display("tb: %0d stream beats under %0d AY clock settings, %0d result beats checked",
             beats_sent, settings_used, checked);
    $display("tb: stream closed by %s", close_mode.name());
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
